/* hw/rtl/smc_pkg.sv */
package smc_pkg;

    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 8;
    localparam int INTERVAL_W  = 4;
    localparam int STEP_W      = 4;
    localparam int MINUTES_W   = 8;

    localparam logic [TIME_W-1:0]     MS_PER_MINUTE  = TIME_W'(60000);
    localparam logic [8:0]            LEVEL_SCALE    = 9'd20;
    localparam logic [8:0]            LEVEL_OFFSET   = 9'd55;
    localparam logic [8:0]            LEVEL_MAX      = 9'd255;
    localparam logic [INTERVAL_W-1:0] FAST_INTERVAL  = INTERVAL_W'(8);
    localparam logic [INTERVAL_W-1:0] SLOW_INTERVAL  = INTERVAL_W'(0);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRACE   = 2'd3;

    localparam logic [MINUTES_W-1:0]  RST_TIMEOUT_MIN = 8'd5;
    localparam logic [STEP_W-1:0]     RST_BRIGHT_STEP = 4'd10;
    localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS = 16'd400;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_GRACE   = 16'd30000;

    typedef enum logic [1:0] {
        MODE_GRACE      = 2'd0,
        MODE_COMPANION  = 2'd1,
        MODE_STANDALONE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        GPS_UNKNOWN = 2'd0,
        GPS_SLOW    = 2'd1,
        GPS_FAST    = 2'd2
    } t_gps;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    // derived settings, recomputed whenever a register is written
    typedef struct packed {
        logic                  timeout_zero;
        logic [TIME_W-1:0]     idle_limit_ms;
        logic [TIME_W-1:0]     fallback_ms;
        logic [CFG_DATA_W-1:0] debounce_ms;
        logic [LEVEL_W-1:0]    restore_level;
    } t_cfg;

    typedef struct packed {
        logic                      command;
        logic [TIME_W-1:0]         now_ms;
        logic                      ignition_pin;
        logic                      peer_paired;
        logic                      peer_link_up;
        logic [TIME_W-1:0]         touch_stamp;
        logic signed [SPEED_W-1:0] speed;
        logic                      at_home;
        logic                      radio_ready;
    } t_item;

    typedef struct packed {
        logic                  sleep_request;
        logic [1:0]            mode;
        logic                  backlight_write;
        logic [LEVEL_W-1:0]    backlight_level;
        logic                  gps_write;
        logic [INTERVAL_W-1:0] gps_interval;
    } t_result;

endpackage

/* hw/rtl/smc_if.sv */
interface smc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [smc_pkg::TIME_W-1:0]         now_ms;
    logic                               ignition_pin;
    logic                               peer_paired;
    logic                               peer_link_up;
    logic [smc_pkg::TIME_W-1:0]         touch_stamp;
    logic signed [smc_pkg::SPEED_W-1:0] speed;
    logic                               at_home;
    logic                               radio_ready;

    modport source (
        output valid, command, now_ms, ignition_pin, peer_paired, peer_link_up,
               touch_stamp, speed, at_home, radio_ready,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, ignition_pin, peer_paired, peer_link_up,
               touch_stamp, speed, at_home, radio_ready,
        output ready
    );
endinterface

interface smc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                sleep_request;
    logic [1:0]                          mode;
    logic                                backlight_write;
    logic [smc_pkg::LEVEL_W-1:0]         backlight_level;
    logic                                gps_write;
    logic [smc_pkg::INTERVAL_W-1:0]      gps_interval;

    modport source (
        output valid, sleep_request, mode, backlight_write, backlight_level,
               gps_write, gps_interval,
        input  ready
    );
    modport sink (
        input  valid, sleep_request, mode, backlight_write, backlight_level,
               gps_write, gps_interval,
        output ready
    );
endinterface

/* hw/rtl/smc_cfg.sv */
module smc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output smc_pkg::t_cfg                     o_cfg
);

    logic [smc_pkg::MINUTES_W-1:0]  r_timeout_min;
    logic [smc_pkg::STEP_W-1:0]     r_bright_step;
    logic [smc_pkg::CFG_DATA_W-1:0] r_debounce_ms;
    logic [smc_pkg::CFG_DATA_W-1:0] r_min_grace;
    smc_pkg::t_cfg                  r_cfg;
    smc_pkg::t_cfg                  n_cfg;
    logic [8:0]                     level_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_min <= smc_pkg::RST_TIMEOUT_MIN;
            r_bright_step <= smc_pkg::RST_BRIGHT_STEP;
            r_debounce_ms <= smc_pkg::RST_DEBOUNCE_MS;
            r_min_grace   <= smc_pkg::RST_MIN_GRACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smc_pkg::CFG_TIMEOUT_MIN: r_timeout_min <= i_cfg_data[smc_pkg::MINUTES_W-1:0];
                smc_pkg::CFG_BRIGHT_STEP: r_bright_step <= i_cfg_data[smc_pkg::STEP_W-1:0];
                smc_pkg::CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data;
                smc_pkg::CFG_MIN_GRACE:   r_min_grace   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived values are registered; the user must write only while idle, which the block does not enforce
    always_comb begin
        level_raw = 9'(r_bright_step) * smc_pkg::LEVEL_SCALE + smc_pkg::LEVEL_OFFSET;
        n_cfg.timeout_zero  = (r_timeout_min == '0);
        n_cfg.idle_limit_ms = smc_pkg::TIME_W'(r_timeout_min) * smc_pkg::MS_PER_MINUTE;
        n_cfg.fallback_ms   = n_cfg.timeout_zero ? smc_pkg::TIME_W'(r_min_grace)
                                                 : n_cfg.idle_limit_ms;
        n_cfg.debounce_ms   = r_debounce_ms;
        n_cfg.restore_level = (level_raw > smc_pkg::LEVEL_MAX) ? 8'hFF
                                                               : level_raw[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_zero  <= 1'b0;
            r_cfg.idle_limit_ms <= smc_pkg::TIME_W'(smc_pkg::RST_TIMEOUT_MIN)
                                   * smc_pkg::MS_PER_MINUTE;
            r_cfg.fallback_ms   <= smc_pkg::TIME_W'(smc_pkg::RST_TIMEOUT_MIN)
                                   * smc_pkg::MS_PER_MINUTE;
            r_cfg.debounce_ms   <= smc_pkg::RST_DEBOUNCE_MS;
            r_cfg.restore_level <= 8'hFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/smc_core.sv */
module smc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  smc_pkg::t_item    i_item,
    input  smc_pkg::t_cfg     i_cfg,
    output smc_pkg::t_result  o_result
);

    smc_pkg::t_mode               r_mode, n_mode;
    smc_pkg::t_gps                r_gps, n_gps;
    logic [smc_pkg::TIME_W-1:0]   r_start_time, n_start_time;
    logic [smc_pkg::TIME_W-1:0]   r_act_time, n_act_time;
    logic [smc_pkg::TIME_W-1:0]   r_disc_time, n_disc_time;
    logic [smc_pkg::TIME_W-1:0]   r_last_touch, n_last_touch;
    logic [smc_pkg::TIME_W-1:0]   r_pin_time, n_pin_time;
    logic                         r_seen, n_seen;
    logic                         r_dimmed, n_dimmed;
    logic                         r_disc_run, n_disc_run;
    logic                         r_pin_stable, n_pin_stable;
    logic                         r_pin_raw, n_pin_raw;
    logic                         r_pin_sleep, n_pin_sleep;

    logic                         start_cmd;
    logic                         connected;
    logic                         moving;
    logic                         touched;
    logic                         grace_done;
    logic                         disc_done;
    logic [smc_pkg::TIME_W-1:0]   act_now;
    logic [smc_pkg::TIME_W-1:0]   idle_ms;
    logic                         idle_over;
    logic [smc_pkg::TIME_W-1:0]   pin_elapsed;
    smc_pkg::t_gps                gps_want;
    smc_pkg::t_result             res;

    assign start_cmd  = (i_item.command == smc_pkg::CMD_START);
    assign connected  = i_item.peer_paired && i_item.peer_link_up;
    assign moving     = !i_item.speed[smc_pkg::SPEED_W-1] && (i_item.speed != '0);
    assign touched    = (i_item.touch_stamp != r_last_touch);
    assign grace_done = (i_item.now_ms - r_start_time) >= i_cfg.fallback_ms;
    assign disc_done  = r_disc_run && ((i_item.now_ms - r_disc_time) >= i_cfg.fallback_ms);
    assign act_now    = (touched || moving) ? i_item.now_ms : r_act_time;
    assign idle_ms    = i_item.now_ms - act_now;
    assign idle_over  = idle_ms >= i_cfg.idle_limit_ms;
    assign gps_want   = i_item.at_home ? smc_pkg::GPS_SLOW : smc_pkg::GPS_FAST;

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (start_cmd) begin
            n_mode = smc_pkg::MODE_GRACE;
        end else begin
            unique case (r_mode)
                smc_pkg::MODE_GRACE: begin
                    if (connected) begin
                        n_mode = smc_pkg::MODE_COMPANION;
                    end else if (grace_done) begin
                        n_mode = r_seen ? smc_pkg::MODE_COMPANION : smc_pkg::MODE_STANDALONE;
                    end
                end
                smc_pkg::MODE_COMPANION: begin
                    if (!connected && disc_done) begin
                        n_mode = smc_pkg::MODE_STANDALONE;
                    end
                end
                smc_pkg::MODE_STANDALONE: begin
                    if (connected) begin
                        n_mode = smc_pkg::MODE_COMPANION;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_gps        = r_gps;
        n_start_time = r_start_time;
        n_act_time   = r_act_time;
        n_disc_time  = r_disc_time;
        n_last_touch = r_last_touch;
        n_pin_time   = r_pin_time;
        n_seen       = r_seen;
        n_dimmed     = r_dimmed;
        n_disc_run   = r_disc_run;
        n_pin_stable = r_pin_stable;
        n_pin_raw    = r_pin_raw;
        n_pin_sleep  = r_pin_sleep;
        pin_elapsed  = '0;
        res          = '0;

        if (start_cmd) begin
            n_start_time = i_item.now_ms;
            n_act_time   = i_item.now_ms;
            n_seen       = 1'b0;
            n_dimmed     = 1'b0;
            n_disc_run   = 1'b0;
            n_disc_time  = '0;
            n_pin_stable = i_item.ignition_pin;
            n_pin_raw    = i_item.ignition_pin;
            n_pin_time   = i_item.now_ms;
            n_pin_sleep  = !i_item.ignition_pin;
        end else begin
            if (touched) begin
                n_last_touch = i_item.touch_stamp;
            end
            n_act_time = act_now;

            unique case (r_mode)
                smc_pkg::MODE_GRACE: begin
                    if (connected) begin
                        n_seen = 1'b1;
                    end
                    if (n_mode == smc_pkg::MODE_COMPANION) begin
                        n_disc_run   = 1'b0;
                        n_pin_stable = 1'b1;
                        n_pin_raw    = i_item.ignition_pin;
                        n_pin_time   = i_item.now_ms;
                        n_pin_sleep  = 1'b0;
                    end
                end
                smc_pkg::MODE_COMPANION: begin
                    if (connected) begin
                        n_disc_run = 1'b0;
                    end else if (!r_disc_run) begin
                        n_disc_run  = 1'b1;
                        n_disc_time = i_item.now_ms;
                    end
                    if (n_mode == smc_pkg::MODE_COMPANION) begin
                        if (i_item.ignition_pin != r_pin_raw) begin
                            n_pin_raw  = i_item.ignition_pin;
                            n_pin_time = i_item.now_ms;
                        end
                        pin_elapsed = i_item.now_ms - n_pin_time;
                        if (n_pin_raw != r_pin_stable &&
                            pin_elapsed >= smc_pkg::TIME_W'(i_cfg.debounce_ms)) begin
                            n_pin_stable = n_pin_raw;
                            n_pin_sleep  = !n_pin_raw;
                        end
                        res.sleep_request = n_pin_sleep;
                    end
                end
                smc_pkg::MODE_STANDALONE: begin
                    if (connected) begin
                        n_disc_run   = 1'b0;
                        n_pin_stable = 1'b1;
                        n_pin_raw    = i_item.ignition_pin;
                        n_pin_time   = i_item.now_ms;
                        n_pin_sleep  = 1'b0;
                        n_gps        = smc_pkg::GPS_UNKNOWN;
                        if (r_dimmed) begin
                            res.backlight_write = 1'b1;
                            res.backlight_level = i_cfg.restore_level;
                            n_dimmed            = 1'b0;
                        end
                    end else begin
                        // with dimming off or idle time under the limit, a dimmed display is brought back
                        if (r_dimmed && (i_cfg.timeout_zero || !idle_over)) begin
                            res.backlight_write = 1'b1;
                            res.backlight_level = i_cfg.restore_level;
                            n_dimmed            = 1'b0;
                        end else if (!r_dimmed && !i_cfg.timeout_zero && idle_over) begin
                            res.backlight_write = 1'b1;
                            res.backlight_level = '0;
                            n_dimmed            = 1'b1;
                        end
                        if (r_gps != gps_want && i_item.radio_ready) begin
                            res.gps_write    = 1'b1;
                            res.gps_interval = i_item.at_home ? smc_pkg::SLOW_INTERVAL
                                                              : smc_pkg::FAST_INTERVAL;
                            n_gps            = gps_want;
                        end
                    end
                end
                default: ;
            endcase
        end
        res.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= smc_pkg::MODE_GRACE;
            r_gps        <= smc_pkg::GPS_UNKNOWN;
            r_start_time <= '0;
            r_act_time   <= '0;
            r_disc_time  <= '0;
            r_last_touch <= '0;
            r_pin_time   <= '0;
            r_seen       <= 1'b0;
            r_dimmed     <= 1'b0;
            r_disc_run   <= 1'b0;
            r_pin_stable <= 1'b1;
            r_pin_raw    <= 1'b1;
            r_pin_sleep  <= 1'b0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_gps        <= n_gps;
            r_start_time <= n_start_time;
            r_act_time   <= n_act_time;
            r_disc_time  <= n_disc_time;
            r_last_touch <= n_last_touch;
            r_pin_time   <= n_pin_time;
            r_seen       <= n_seen;
            r_dimmed     <= n_dimmed;
            r_disc_run   <= n_disc_run;
            r_pin_stable <= n_pin_stable;
            r_pin_raw    <= n_pin_raw;
            r_pin_sleep  <= n_pin_sleep;
        end
    end

    assign o_result = res;

    a_sleep_only_companion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.sleep_request |-> res.mode == smc_pkg::MODE_COMPANION)
        else $error("sleep requested outside companion mode");

    a_gps_needs_radio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.gps_write |-> i_item.radio_ready
                                    && r_mode == smc_pkg::MODE_STANDALONE)
        else $error("gps write without radio or outside standalone mode");

    a_dim_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.backlight_write && res.backlight_level == '0 |=> r_dimmed)
        else $error("backlight turned off without dimmed flag");

    a_start_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && start_cmd |=> r_mode == smc_pkg::MODE_GRACE && !r_dimmed && !r_disc_run)
        else $error("start command did not reinitialize modes");

endmodule

/* hw/rtl/sleep_mode_controller.sv */
// Channel   Direction  Carries
// i_in      sink       command, now_ms, ignition pin, link status, touch, speed, home, radio
// o_out     source     sleep_request, mode, backlight write/level, gps write/interval
// i_cfg_*   write      timeout_minutes, brightness_step, debounce_ms, min_grace_ms
//
// One item per cycle sustained while o_out takes results; an accepted item passes from the
// input register through single-pass mode/timer logic into the result register on o_out.
// Synchronous active-low reset; no clearing pass, the block is ready right after reset.
// i_in.ready drops only while both the input and result registers are full and o_out
// is stalled; a waiting result still lets one more item into the input register.
module sleep_mode_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    smc_in_if.sink                            i_in,
    smc_out_if.source                         o_out
);

    smc_pkg::t_cfg     cfg;
    smc_pkg::t_item    r_item;
    smc_pkg::t_result  core_res;
    smc_pkg::t_result  r_res;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              fire;
    logic              in_take;

    assign fire    = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command      <= i_in.command;
            r_item.now_ms       <= i_in.now_ms;
            r_item.ignition_pin <= i_in.ignition_pin;
            r_item.peer_paired  <= i_in.peer_paired;
            r_item.peer_link_up <= i_in.peer_link_up;
            r_item.touch_stamp  <= i_in.touch_stamp;
            r_item.speed        <= i_in.speed;
            r_item.at_home      <= i_in.at_home;
            r_item.radio_ready  <= i_in.radio_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    smc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    smc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.sleep_request   = r_res.sleep_request;
    assign o_out.mode            = r_res.mode;
    assign o_out.backlight_write = r_res.backlight_write;
    assign o_out.backlight_level = r_res.backlight_level;
    assign o_out.gps_write       = r_res.gps_write;
    assign o_out.gps_interval    = r_res.gps_interval;

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;

    // keeps the expected view of the controller and the results still owed
    class outcome_board;
        logic [smc_pkg::MINUTES_W-1:0]  timeout_min;
        logic [smc_pkg::STEP_W-1:0]     bright_step;
        logic [smc_pkg::CFG_DATA_W-1:0] debounce_ms;
        logic [smc_pkg::CFG_DATA_W-1:0] min_grace_ms;

        smc_pkg::t_mode             op_mode;
        logic [smc_pkg::TIME_W-1:0] start_time;
        logic                       companion_seen;
        logic                       dimmed;
        logic [smc_pkg::TIME_W-1:0] activity_time;
        logic [smc_pkg::TIME_W-1:0] disconnect_time;
        logic                       disc_running;
        logic [smc_pkg::TIME_W-1:0] last_touch;
        smc_pkg::t_gps              gps_setting;
        logic                       pin_stable;
        logic                       pin_raw;
        logic [smc_pkg::TIME_W-1:0] pin_change_time;
        logic                       pin_sleep;

        smc_pkg::t_result expected_outcomes[$];
        int errors, n_items, n_results, n_sleep, n_backlight, n_gps;

        function new();
            timeout_min     = smc_pkg::RST_TIMEOUT_MIN;
            bright_step     = smc_pkg::RST_BRIGHT_STEP;
            debounce_ms     = smc_pkg::RST_DEBOUNCE_MS;
            min_grace_ms    = smc_pkg::RST_MIN_GRACE;
            op_mode         = smc_pkg::MODE_GRACE;
            start_time      = '0;
            companion_seen  = 1'b0;
            dimmed          = 1'b0;
            activity_time   = '0;
            disconnect_time = '0;
            disc_running    = 1'b0;
            last_touch      = '0;
            gps_setting     = smc_pkg::GPS_UNKNOWN;
            pin_stable      = 1'b1;
            pin_raw         = 1'b1;
            pin_change_time = '0;
            pin_sleep       = 1'b0;
            errors          = 0;
            n_items         = 0;
            n_results       = 0;
            n_sleep         = 0;
            n_backlight     = 0;
            n_gps           = 0;
        endfunction

        function void write_reg(logic [smc_pkg::CFG_IDX_W-1:0] idx,
                                logic [smc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                smc_pkg::CFG_TIMEOUT_MIN: timeout_min  = data[smc_pkg::MINUTES_W-1:0];
                smc_pkg::CFG_BRIGHT_STEP: bright_step  = data[smc_pkg::STEP_W-1:0];
                smc_pkg::CFG_DEBOUNCE_MS: debounce_ms  = data;
                smc_pkg::CFG_MIN_GRACE:   min_grace_ms = data;
                default: ;
            endcase
        endfunction

        function logic [smc_pkg::TIME_W-1:0] fallback_ms();
            if (timeout_min == 0)
                return smc_pkg::TIME_W'(min_grace_ms);
            return smc_pkg::TIME_W'(timeout_min) * smc_pkg::MS_PER_MINUTE;
        endfunction

        function logic [smc_pkg::LEVEL_W-1:0] restore_level();
            int v;
            v = int'(bright_step) * int'(smc_pkg::LEVEL_SCALE) + int'(smc_pkg::LEVEL_OFFSET);
            return (v > int'(smc_pkg::LEVEL_MAX)) ? smc_pkg::LEVEL_W'(smc_pkg::LEVEL_MAX)
                                                   : smc_pkg::LEVEL_W'(v);
        endfunction

        function void rearm(logic pin, logic [smc_pkg::TIME_W-1:0] now);
            pin_stable      = 1'b1;
            pin_raw         = pin;
            pin_change_time = now;
            pin_sleep       = 1'b0;
        endfunction

        function logic debounce(logic pin, logic [smc_pkg::TIME_W-1:0] now);
            logic [smc_pkg::TIME_W-1:0] held;
            if (pin != pin_raw) begin
                pin_raw         = pin;
                pin_change_time = now;
            end
            held = now - pin_change_time;
            if (pin_raw != pin_stable && held >= smc_pkg::TIME_W'(debounce_ms)) begin
                pin_stable = pin_raw;
                pin_sleep  = (pin_raw == 1'b0);
            end
            return pin_sleep;
        endfunction

        function smc_pkg::t_result predict_outcome(smc_pkg::t_item it);
            smc_pkg::t_result           r;
            logic                       act;
            logic                       connected;
            logic                       switched;
            smc_pkg::t_gps              want;
            logic [smc_pkg::TIME_W-1:0] idle;
            logic [smc_pkg::TIME_W-1:0] lim;
            r = '0;
            connected = it.peer_paired & it.peer_link_up;
            if (it.command == smc_pkg::CMD_START) begin
                start_time      = it.now_ms;
                op_mode         = smc_pkg::MODE_GRACE;
                companion_seen  = 1'b0;
                dimmed          = 1'b0;
                activity_time   = it.now_ms;
                disc_running    = 1'b0;
                disconnect_time = '0;
                pin_stable      = it.ignition_pin;
                pin_raw         = it.ignition_pin;
                pin_change_time = it.now_ms;
                pin_sleep       = (it.ignition_pin == 1'b0);
            end else begin
                act = 1'b0;
                if (it.touch_stamp != last_touch) begin
                    last_touch = it.touch_stamp;
                    act = 1'b1;
                end
                if ($signed(it.speed) > 0)
                    act = 1'b1;
                if (act)
                    activity_time = it.now_ms;

                case (op_mode)
                    smc_pkg::MODE_GRACE: begin
                        if (connected) begin
                            companion_seen = 1'b1;
                            op_mode        = smc_pkg::MODE_COMPANION;
                            disc_running   = 1'b0;
                            rearm(it.ignition_pin, it.now_ms);
                        end else if (it.now_ms - start_time >= fallback_ms()) begin
                            if (companion_seen) begin
                                op_mode      = smc_pkg::MODE_COMPANION;
                                disc_running = 1'b0;
                                rearm(it.ignition_pin, it.now_ms);
                            end else begin
                                op_mode = smc_pkg::MODE_STANDALONE;
                            end
                        end
                    end
                    smc_pkg::MODE_COMPANION: begin
                        switched = 1'b0;
                        if (connected) begin
                            disc_running = 1'b0;
                        end else if (!disc_running) begin
                            disc_running    = 1'b1;
                            disconnect_time = it.now_ms;
                        end else if (it.now_ms - disconnect_time >= fallback_ms()) begin
                            op_mode  = smc_pkg::MODE_STANDALONE;
                            switched = 1'b1;
                        end
                        if (!switched)
                            r.sleep_request = debounce(it.ignition_pin, it.now_ms);
                    end
                    smc_pkg::MODE_STANDALONE: begin
                        if (connected) begin
                            op_mode      = smc_pkg::MODE_COMPANION;
                            disc_running = 1'b0;
                            rearm(it.ignition_pin, it.now_ms);
                            if (dimmed) begin
                                r.backlight_write = 1'b1;
                                r.backlight_level = restore_level();
                                dimmed = 1'b0;
                            end
                            gps_setting = smc_pkg::GPS_UNKNOWN;
                        end else begin
                            want = it.at_home ? smc_pkg::GPS_SLOW : smc_pkg::GPS_FAST;
                            if (timeout_min == 0) begin
                                if (dimmed) begin
                                    r.backlight_write = 1'b1;
                                    r.backlight_level = restore_level();
                                    dimmed = 1'b0;
                                end
                            end else begin
                                idle = it.now_ms - activity_time;
                                lim  = smc_pkg::TIME_W'(timeout_min) * smc_pkg::MS_PER_MINUTE;
                                if (idle >= lim && !dimmed) begin
                                    r.backlight_write = 1'b1;
                                    r.backlight_level = '0;
                                    dimmed = 1'b1;
                                end else if (idle < lim && dimmed) begin
                                    r.backlight_write = 1'b1;
                                    r.backlight_level = restore_level();
                                    dimmed = 1'b0;
                                end
                            end
                            if (gps_setting != want && it.radio_ready) begin
                                r.gps_write    = 1'b1;
                                r.gps_interval = it.at_home ? smc_pkg::SLOW_INTERVAL
                                                            : smc_pkg::FAST_INTERVAL;
                                gps_setting    = want;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.mode = op_mode;
            return r;
        endfunction

        function void note_item(smc_pkg::t_item it);
            n_items++;
            expected_outcomes.push_back(predict_outcome(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(smc_pkg::t_result got);
            smc_pkg::t_result want;
            n_results++;
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with nothing expected", $time, got);
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("sleep_request", want.sleep_request, got.sleep_request);
            compare_field("mode", want.mode, got.mode);
            compare_field("backlight_write", want.backlight_write, got.backlight_write);
            compare_field("backlight_level", want.backlight_level, got.backlight_level);
            compare_field("gps_write", want.gps_write, got.gps_write);
            compare_field("gps_interval", want.gps_interval, got.gps_interval);
            if (got.sleep_request === 1'b1)
                n_sleep++;
            if (got.backlight_write === 1'b1)
                n_backlight++;
            if (got.gps_write === 1'b1)
                n_gps++;
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [smc_pkg::CFG_DATA_W-1:0] cfg_data;

    smc_in_if  in_bus ();
    smc_out_if out_bus ();

    sleep_mode_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    outcome_board board;
    int tx_style;
    int rx_style;
    bit rx_hold_req;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // style 0: back to back, 1: short gaps, 2: full range
    function automatic int draw_gap(int style);
        if (style == 0)
            return 0;
        if (style == 1)
            return $urandom_range(0, 3);
        return $urandom_range(0, 19);
    endfunction

    function automatic smc_pkg::t_item make_item(logic cmd, logic [smc_pkg::TIME_W-1:0] now,
                                                 logic pin, logic paired, logic link,
                                                 logic [smc_pkg::TIME_W-1:0] touch,
                                                 logic [smc_pkg::SPEED_W-1:0] spd,
                                                 logic home, logic radio);
        smc_pkg::t_item it;
        it.command      = cmd;
        it.now_ms       = now;
        it.ignition_pin = pin;
        it.peer_paired  = paired;
        it.peer_link_up = link;
        it.touch_stamp  = touch;
        it.speed        = spd;
        it.at_home      = home;
        it.radio_ready  = radio;
        return it;
    endfunction

    task automatic send_item(input smc_pkg::t_item it, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_bus.command      <= it.command;
        in_bus.now_ms       <= it.now_ms;
        in_bus.ignition_pin <= it.ignition_pin;
        in_bus.peer_paired  <= it.peer_paired;
        in_bus.peer_link_up <= it.peer_link_up;
        in_bus.touch_stamp  <= it.touch_stamp;
        in_bus.speed        <= it.speed;
        in_bus.at_home      <= it.at_home;
        in_bus.radio_ready  <= it.radio_ready;
        in_bus.valid        <= 1'b1;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        board.note_item(it);
    endtask

    // stop offering, wait for every owed result, then let the bench settle
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (board.expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [smc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [smc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        board.write_reg(idx, data);
    endtask

    // result side
    initial begin
        int               gap;
        smc_pkg::t_result got;
        out_bus.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                @(negedge i_clk);
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap(rx_style);
            if (gap > 0) begin
                @(negedge i_clk);
                out_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            got.sleep_request   = out_bus.sleep_request;
            got.mode            = out_bus.mode;
            got.backlight_write = out_bus.backlight_write;
            got.backlight_level = out_bus.backlight_level;
            got.gps_write       = out_bus.gps_write;
            got.gps_interval    = out_bus.gps_interval;
            board.check_result(got);
        end
    end

    initial begin
        smc_pkg::t_item              it;
        int                          phase;
        int                          n;
        int                          k;
        int                          r;
        int                          random_items;
        logic                        cmd;
        logic                        paired;
        logic                        link;
        logic [smc_pkg::SPEED_W-1:0] spd;
        logic [smc_pkg::TIME_W-1:0]  cur_now;
        logic [smc_pkg::TIME_W-1:0]  cur_touch;
        logic                        link_on;
        logic                        pin_lvl;
        logic                        home_lvl;
        logic [7:0]                  tmo;
        logic [3:0]                  stp;
        logic [15:0]                 dbn;
        logic [15:0]                 grc;

        board = new();
        tx_style    = 2;
        rx_style    = 2;
        rx_hold_req = 1'b0;
        n_settings  = 0;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_bus.valid        = 1'b0;
        in_bus.command      = 1'b0;
        in_bus.now_ms       = '0;
        in_bus.ignition_pin = 1'b1;
        in_bus.peer_paired  = 1'b0;
        in_bus.peer_link_up = 1'b0;
        in_bus.touch_stamp  = '0;
        in_bus.speed        = '0;
        in_bus.at_home      = 1'b0;
        in_bus.radio_ready  = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 1 min timeout, saturating step, short debounce
        set_register(smc_pkg::CFG_TIMEOUT_MIN, 16'h3401);
        set_register(smc_pkg::CFG_BRIGHT_STEP, 16'hFFFF);
        set_register(smc_pkg::CFG_DEBOUNCE_MS, 16'd100);
        set_register(smc_pkg::CFG_MIN_GRACE, 16'd500);
        n_settings++;

        // tick straight out of reset, then start with pin low
        send_item(make_item(smc_pkg::CMD_TICK, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0, 16'd0,
                            1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_START, 32'd1000, 1'b0, 1'b0, 1'b0, 32'd0, 16'd0,
                            1'b0, 1'b0), draw_gap(tx_style));
        // paired but link down, touch, most negative speed
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1010, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF,
                            16'h8000, 1'b0, 1'b0), draw_gap(tx_style));
        // companion comes up: no sleep on the switch tick
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1020, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1030, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1200, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1300, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1500, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        // link lost, then disconnect timeout without pin evaluation
        send_item(make_item(smc_pkg::CMD_TICK, 32'd1600, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd61600, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        // standalone: dim and fast gps
        send_item(make_item(smc_pkg::CMD_TICK, 32'd61700, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                            16'd0, 1'b0, 1'b1), draw_gap(tx_style));
        // movement restores, radio not ready blocks the gps write
        send_item(make_item(smc_pkg::CMD_TICK, 32'd61800, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                            16'h7FFF, 1'b1, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd61900, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                            16'd0, 1'b1, 1'b1), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'd200000, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                            16'd0, 1'b1, 1'b1), draw_gap(tx_style));
        // reconnect while dimmed
        send_item(make_item(smc_pkg::CMD_TICK, 32'd200100, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                            16'd0, 1'b1, 1'b1), draw_gap(tx_style));
        // start near the top of the time range, grace expires across the wrap
        send_item(make_item(smc_pkg::CMD_START, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0,
                            32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'h0000_0100, 1'b1, 1'b0, 1'b0,
                            32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'h0000_F000, 1'b1, 1'b1, 1'b0,
                            32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'h0000_F010, 1'b0, 1'b0, 1'b0, 32'd0,
                            16'd1, 1'b0, 1'b1), draw_gap(tx_style));
        send_item(make_item(smc_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0,
                            16'hFFFF, 1'b1, 1'b1), draw_gap(tx_style));
        drain();

        cur_now      = $urandom;
        cur_touch    = $urandom;
        link_on      = 1'b0;
        pin_lvl      = 1'b1;
        home_lvl     = 1'b0;
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                tmo = 8'd0;
                stp = 4'd0;
                dbn = 16'd0;
                grc = 16'd0;
            end else if (phase == 1) begin
                tmo = 8'd255;
                stp = 4'd15;
                dbn = 16'hFFFF;
                grc = 16'hFFFF;
            end else begin
                r = $urandom_range(0, 9);
                tmo = (r < 3) ? 8'd0 : (r < 6) ? 8'd1 : (r < 8) ? 8'd2 :
                      (r < 9) ? 8'($urandom_range(3, 254)) : 8'd255;
                stp = 4'($urandom_range(0, 15));
                r = $urandom_range(0, 9);
                dbn = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 2000));
                r = $urandom_range(0, 9);
                grc = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 5000));
            end
            // unused upper data bits carry noise
            set_register(smc_pkg::CFG_TIMEOUT_MIN, {8'($urandom), tmo});
            set_register(smc_pkg::CFG_BRIGHT_STEP, {12'($urandom), stp});
            set_register(smc_pkg::CFG_DEBOUNCE_MS, dbn);
            set_register(smc_pkg::CFG_MIN_GRACE, grc);
            n_settings++;

            tx_style = (phase == 2) ? 0 : $urandom_range(0, 2);
            rx_style = $urandom_range(0, 2);
            n = $urandom_range(40, 120);
            for (k = 0; k < n; k++) begin
                if (phase == 2 && k == 10)
                    rx_hold_req = 1'b1;
                if (phase == 3 && k == n / 2)
                    drain();

                // phases 0 and 1 always restart; later ones mostly restart, else keep state across the new settings
                cmd = ((k == 0) && (phase < 2 || $urandom_range(0, 9) < 7)) ||
                      ($urandom_range(0, 99) == 0);

                r = $urandom_range(0, 99);
                if (r < 60)
                    cur_now = cur_now + $urandom_range(0, 300);
                else if (r < 85)
                    cur_now = cur_now + $urandom_range(300, 5000);
                else if (r < 95)
                    cur_now = cur_now + $urandom_range(5000, 70000);
                else if (r < 99)
                    cur_now = cur_now + $urandom_range(70000, 400000);
                else
                    cur_now = $urandom;

                if ($urandom_range(0, 19) == 0)
                    link_on = ~link_on;
                if (link_on) begin
                    paired = 1'b1;
                    link   = 1'b1;
                end else begin
                    r = $urandom_range(0, 2);
                    paired = (r == 2);
                    link   = (r == 1);
                end
                if ($urandom_range(0, 9) == 0)
                    pin_lvl = ~pin_lvl;
                if ($urandom_range(0, 9) == 0)
                    cur_touch = $urandom;
                if ($urandom_range(0, 19) == 0)
                    home_lvl = ~home_lvl;

                r = $urandom_range(0, 99);
                if (r < 60)
                    spd = '0;
                else if (r < 75)
                    spd = 16'(-$urandom_range(1, 32768));
                else if (r < 95)
                    spd = 16'($urandom_range(1, 32767));
                else
                    spd = 16'($urandom);

                it = make_item(cmd, cur_now, pin_lvl, paired, link, cur_touch, spd,
                               home_lvl, ($urandom_range(0, 9) != 0));
                send_item(it, draw_gap(tx_style));
            end
            random_items += n;
            drain();
            phase++;
        end

        $display("Covered %0d items under %0d register settings, with a long output stall",
                 board.n_items, n_settings);
        $display("Results seen: %0d sleep requests, %0d backlight writes, %0d GPS writes",
                 board.n_sleep, board.n_backlight, board.n_gps);
        if (board.expected_outcomes.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     board.expected_outcomes.size());
        if (board.errors == 0 && board.expected_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/smc_pkg.sv
hw/rtl/smc_if.sv
hw/rtl/smc_cfg.sv
hw/rtl/smc_core.sv
hw/rtl/sleep_mode_controller.sv
sim/testbench.sv
